[rtl/ssec_pkg.sv]
// ----------------------------------------------------------------------------
// Sturm count package
// Shared types, constants and single-precision helper functions for the
// Sturm sequence eigenvalue counter.
// ----------------------------------------------------------------------------
package ssec_pkg;

   localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
   localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
   localparam logic [31:0] FP_SIGN     = 32'h8000_0000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam int          QUEUE_DEPTH = 2;
   localparam int          FP_LATENCY  = 3;
   localparam int          DIV_STEPS   = 7;
   localparam int          DIV_BITS    = 4;
   localparam int          DIV_Q_WIDTH = DIV_STEPS * DIV_BITS;

   typedef struct packed {
      logic               sign;
      logic signed [10:0] exp;
      logic [23:0]        sig;
   } fp_unpacked_type;

   typedef struct packed {
      logic [31:0] diff;
      logic [31:0] square;
      logic        last_row;
   } queue_entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_BUSY,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIVIDE,
      B_ROUND,
      B_SUBTRACT,
      B_UPDATE
   } back_state_type;

   function automatic logic fp_is_nan(logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(logic [31:0] v);
      return v[30:0] == 31'h7F80_0000;
   endfunction

   function automatic logic fp_is_zero(logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic logic [4:0] fp_lzc27(logic [26:0] v);
      logic [4:0] n;
      n = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) begin
            n = 5'(26 - i);
         end
      end
      return n;
   endfunction

   // Subnormal inputs are normalised here, so their exponent may drop below one.
   function automatic fp_unpacked_type fp_unpack(logic [31:0] v);
      fp_unpacked_type u;
      logic [4:0]      lz;
      u.sign = v[31];
      if (v[30:23] == 8'd0) begin
         lz    = fp_lzc27({4'd0, v[22:0]}) - 5'd3;
         u.sig = {1'b0, v[22:0]} << lz;
         u.exp = 11'sd1 - $signed({6'd0, lz});
      end else begin
         u.sig = {1'b1, v[22:0]};
         u.exp = $signed({3'd0, v[30:23]});
      end
      return u;
   endfunction

   // Bit 26 of sig carries weight 2^(exp-127); bit 0 is sticky.
   function automatic logic [31:0] fp_round(logic sign, logic signed [10:0] exp,
                                            logic [26:0] sig);
      logic signed [11:0] amt;
      logic [4:0]         sh;
      logic [58:0]        wide;
      logic [26:0]        s;
      logic               st;
      logic               up;
      logic [24:0]        mant;
      logic [9:0]         ebase;
      logic [32:0]        total;
      if (exp <= 11'sd0) begin
         amt   = 12'sd1 - {exp[10], exp};
         sh    = (amt > 12'sd31) ? 5'd31 : amt[4:0];
         ebase = 10'd0;
      end else begin
         amt   = 12'sd0;
         sh    = 5'd0;
         ebase = exp[9:0] - 10'd1;
      end
      wide  = {sig, 32'd0} >> sh;
      s     = wide[58:32];
      st    = |wide[31:0];
      up    = s[2] & (s[3] | s[1] | s[0] | st);
      mant  = {1'b0, s[26:3]} + {24'd0, up};
      total = {ebase, 23'd0} + {8'd0, mant};
      if (total[32:23] >= 10'd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      return {sign, total[30:0]};
   endfunction

endpackage

[rtl/ssec_fp_add.sv]
// ----------------------------------------------------------------------------
// Single-precision adder
// Three-stage pipelined IEEE single adder with round to nearest even:
// alignment, addition with leading-zero count, then normalisation and rounding.
// ----------------------------------------------------------------------------
module ssec_fp_add
   import ssec_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result
);

   fp_unpacked_type    ua;
   fp_unpacked_type    ub;
   fp_unpacked_type    big;
   fp_unpacked_type    little;
   logic               a_big;
   logic signed [10:0] exp_gap;
   logic [4:0]         sh;
   logic [58:0]        wide;
   logic [26:0]        ma_in, mb_in;
   logic               spec_in;
   logic [31:0]        spec_bits_in;

   logic [26:0]        ma_ff, mb_ff;
   logic               sub_ff, sign_ff, spec_ff;
   logic signed [10:0] exp_ff;
   logic [31:0]        spec_bits_ff;

   logic [27:0]        sum_in;
   logic [4:0]         lz_in;
   logic [27:0]        sum_ff;
   logic [4:0]         lz_ff;
   logic               sign2_ff, spec2_ff;
   logic signed [10:0] exp2_ff;
   logic [31:0]        spec_bits2_ff;

   logic [31:0]        result_in;
   logic [31:0]        result_ff;

   always_comb begin
      ua      = fp_unpack(a);
      ub      = fp_unpack(b);
      a_big   = (ua.exp > ub.exp) || ((ua.exp == ub.exp) && (ua.sig >= ub.sig));
      big     = a_big ? ua : ub;
      little  = a_big ? ub : ua;
      exp_gap = big.exp - little.exp;
      sh      = (exp_gap > 11'sd31) ? 5'd31 : exp_gap[4:0];
      wide    = {little.sig, 3'd0, 32'd0} >> sh;
      ma_in   = {big.sig, 3'd0};
      mb_in   = wide[58:32] | {26'd0, |wide[31:0]};
      spec_in      = 1'b1;
      spec_bits_in = FP_QNAN;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         spec_bits_in = FP_QNAN;
      end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
         spec_bits_in = FP_QNAN;
      end else if (fp_is_inf(a)) begin
         spec_bits_in = a;
      end else if (fp_is_inf(b)) begin
         spec_bits_in = b;
      end else if (fp_is_zero(a) && fp_is_zero(b)) begin
         spec_bits_in = {a[31] & b[31], 31'd0};
      end else if (fp_is_zero(a)) begin
         spec_bits_in = b;
      end else if (fp_is_zero(b)) begin
         spec_bits_in = a;
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      sub_ff       <= big.sign ^ little.sign;
      sign_ff      <= big.sign;
      exp_ff       <= big.exp;
      spec_ff      <= spec_in;
      spec_bits_ff <= spec_bits_in;
   end

   always_comb begin
      if (sub_ff) begin
         sum_in = {1'b0, ma_ff} - {1'b0, mb_ff};
      end else begin
         sum_in = {1'b0, ma_ff} + {1'b0, mb_ff};
      end
      lz_in = fp_lzc27(sum_in[26:0]);
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      lz_ff         <= lz_in;
      sign2_ff      <= sign_ff;
      exp2_ff       <= exp_ff;
      spec2_ff      <= spec_ff;
      spec_bits2_ff <= spec_bits_ff;
   end

   always_comb begin
      if (spec2_ff) begin
         result_in = spec_bits2_ff;
      end else if (sum_ff == 28'd0) begin
         result_in = 32'd0;
      end else if (sum_ff[27]) begin
         result_in = fp_round(sign2_ff, exp2_ff + 11'sd1,
                              {sum_ff[27:2], sum_ff[1] | sum_ff[0]});
      end else begin
         result_in = fp_round(sign2_ff, exp2_ff - $signed({6'd0, lz_ff}),
                              sum_ff[26:0] << lz_ff);
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

[rtl/ssec_front.sv]
// ----------------------------------------------------------------------------
// Sturm count front end
// Accepts one row, forms diag - shift and coupling squared in parallel
// pipelines, then hands the pair to the queue.
// ----------------------------------------------------------------------------
module ssec_front
   import ssec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [31:0]     req_diag_value,
   input  logic [31:0]     req_coupling_value,
   input  logic [31:0]     req_shift,
   input  logic            req_last_row,
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_data
);

   localparam int WAIT_W = $clog2(FP_LATENCY);

   front_state_type    state_ff, state_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [31:0]        diag_ff, shift_ff, coupling_ff;
   logic               last_ff;
   logic [31:0]        diff;

   fp_unpacked_type    uc;
   logic [23:0]        msig_ff;
   logic signed [10:0] mexp_ff, mexp2_ff;
   logic               mspec_ff, mspec2_ff;
   logic [31:0]        mspec_bits_in, mspec_bits_ff, mspec_bits2_ff;
   logic [47:0]        prod_ff;
   logic [31:0]        square_in, square_ff;

   ssec_fp_add u_sub (
      .clock  (clock),
      .a      (diag_ff),
      .b      (shift_ff ^ FP_SIGN),
      .result (diff)
   );

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         diag_ff     <= req_diag_value;
         shift_ff    <= req_shift;
         coupling_ff <= req_coupling_value;
         last_ff     <= req_last_row;
      end
   end

   always_comb begin
      uc = fp_unpack(coupling_ff);
      if (fp_is_nan(coupling_ff)) begin
         mspec_bits_in = FP_QNAN;
      end else if (fp_is_inf(coupling_ff)) begin
         mspec_bits_in = 32'h7F80_0000;
      end else begin
         mspec_bits_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      msig_ff        <= uc.sig;
      mexp_ff        <= (uc.exp <<< 1) - 11'sd127;
      mspec_ff       <= fp_is_nan(coupling_ff) || fp_is_inf(coupling_ff)
                        || fp_is_zero(coupling_ff);
      mspec_bits_ff  <= mspec_bits_in;
      prod_ff        <= msig_ff * msig_ff;
      mexp2_ff       <= mexp_ff;
      mspec2_ff      <= mspec_ff;
      mspec_bits2_ff <= mspec_bits_ff;
   end

   always_comb begin
      if (mspec2_ff) begin
         square_in = mspec_bits2_ff;
      end else if (prod_ff[47]) begin
         square_in = fp_round(1'b0, mexp2_ff + 11'sd1, {prod_ff[47:22], |prod_ff[21:0]});
      end else begin
         square_in = fp_round(1'b0, mexp2_ff, {prod_ff[46:21], |prod_ff[20:0]});
      end
   end

   always_ff @(posedge clock) begin
      square_ff <= square_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      wait_in    = wait_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            wait_in   = '0;
            if (req_valid) begin
               state_in = F_BUSY;
            end
         end
         F_BUSY: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_W'(FP_LATENCY - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_data = '{diff: diff, square: square_ff, last_row: last_ff};

endmodule

[rtl/ssec_queue.sv]
// ----------------------------------------------------------------------------
// Sturm count queue
// Small first-in first-out buffer between the front end and the pivot unit.
// ----------------------------------------------------------------------------
module ssec_queue
   import ssec_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_valid,
   output logic            wr_ready,
   input  queue_entry_type wr_data,
   output logic            rd_valid,
   input  logic            rd_ready,
   output queue_entry_type rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   queue_entry_type entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]     fill_ff;
   logic            push, pop;

   assign wr_ready = fill_ff != (AW + 1)'(DEPTH);
   assign rd_valid = fill_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/ssec_back.sv]
// ----------------------------------------------------------------------------
// Sturm count pivot unit
// Divides the square by the pivot four quotient bits a cycle, subtracts the
// quotient from the difference, counts negative pivots and emits the count.
// ----------------------------------------------------------------------------
module ssec_back
   import ssec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  queue_entry_type pop_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [15:0]     rsp_eig_count
);

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int WAIT_W = $clog2(FP_LATENCY);

   back_state_type     state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [31:0]        pivot_ff, pivot_in;
   logic [15:0]        count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_count_ff, rsp_count_in;

   logic [31:0]        diff_ff;
   logic               last_ff;
   logic [24:0]        rem_ff, rem_in, rem_next, rem_init;
   logic [23:0]        divisor_ff;
   logic [DIV_Q_WIDTH-1:0] quo_ff, quo_in, quo_next;
   logic signed [10:0] qexp_ff, qexp_in;
   logic               qsign_ff;
   logic               spec_ff, spec_in;
   logic [31:0]        spec_bits_ff, spec_bits_in;
   logic [31:0]        quot_ff, quot_in;
   logic [31:0]        pivot_new;

   fp_unpacked_type    us, up;
   logic               neg;
   logic [15:0]        count_next;

   ssec_fp_add u_sub (
      .clock  (clock),
      .a      (diff_ff),
      .b      (quot_ff ^ FP_SIGN),
      .result (pivot_new)
   );

   // Division set-up for the item at the head of the queue.
   always_comb begin
      us      = fp_unpack(pop_data.square);
      up      = fp_unpack(pivot_ff);
      qexp_in = us.exp - up.exp + 11'sd127;
      if (us.sig < up.sig) begin
         rem_init = {us.sig, 1'b0};
         qexp_in  = qexp_in - 11'sd1;
      end else begin
         rem_init = {1'b0, us.sig};
      end
      spec_in      = 1'b1;
      spec_bits_in = FP_QNAN;
      if (fp_is_nan(pop_data.square) || fp_is_nan(pivot_ff)) begin
         spec_bits_in = FP_QNAN;
      end else if (fp_is_inf(pop_data.square) && fp_is_inf(pivot_ff)) begin
         spec_bits_in = FP_QNAN;
      end else if (fp_is_zero(pop_data.square) && fp_is_zero(pivot_ff)) begin
         spec_bits_in = FP_QNAN;
      end else if (fp_is_inf(pop_data.square) || fp_is_zero(pivot_ff)) begin
         spec_bits_in = {us.sign ^ up.sign, 8'hFF, 23'd0};
      end else if (fp_is_zero(pop_data.square) || fp_is_inf(pivot_ff)) begin
         spec_bits_in = {us.sign ^ up.sign, 31'd0};
      end else begin
         spec_in = 1'b0;
      end
   end

   always_comb begin
      rem_next = rem_ff;
      quo_next = quo_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         if (rem_next >= {1'b0, divisor_ff}) begin
            rem_next = rem_next - {1'b0, divisor_ff};
            quo_next = {quo_next[DIV_Q_WIDTH-2:0], 1'b1};
         end else begin
            quo_next = {quo_next[DIV_Q_WIDTH-2:0], 1'b0};
         end
         rem_next = {rem_next[23:0], 1'b0};
      end
   end

   always_comb begin
      if (spec_ff) begin
         quot_in = spec_bits_ff;
      end else begin
         quot_in = fp_round(qsign_ff, qexp_ff,
                            {quo_ff[DIV_Q_WIDTH-1:2],
                             quo_ff[1] | quo_ff[0] | (rem_ff != 25'd0)});
      end
      neg = pivot_new[31] && !fp_is_zero(pivot_new) && !fp_is_nan(pivot_new);
      count_next = count_ff + {15'd0, neg && (count_ff != COUNT_MAX)};
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         diff_ff      <= pop_data.diff;
         last_ff      <= pop_data.last_row;
         divisor_ff   <= up.sig;
         qsign_ff     <= us.sign ^ up.sign;
         qexp_ff      <= qexp_in;
         spec_ff      <= spec_in;
         spec_bits_ff <= spec_bits_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      if (state_ff == B_ROUND) begin
         quot_ff <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         wait_ff      <= '0;
         pivot_ff     <= FP_ONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         pivot_ff     <= pivot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      wait_in      = wait_ff;
      pivot_in     = pivot_ff;
      count_in     = count_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            step_in   = '0;
            if (pop_valid) begin
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = B_ROUND;
            end
         end
         B_ROUND: begin
            wait_in  = '0;
            state_in = B_SUBTRACT;
         end
         B_SUBTRACT: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_W'(FP_LATENCY - 1)) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (!last_ff) begin
               pivot_in = pivot_new;
               count_in = count_next;
               state_in = B_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_next;
               pivot_in     = FP_ONE;
               count_in     = '0;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (state_ff == B_IDLE) begin
         quo_in = '0;
         rem_in = rem_init;
      end else if (state_ff == B_DIVIDE) begin
         quo_in = quo_next;
         rem_in = rem_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_eig_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (count_ff == COUNT_MAX) |=> (count_ff == COUNT_MAX) || (count_ff == 16'd0))
      else $error("running count left saturation");
   a_pop_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> (state_ff == B_DIVIDE) && (step_ff == '0))
      else $error("popped item did not start division");
   a_response_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_count_ff))
      else $error("pending count overwritten");
`endif

endmodule

[rtl/sturm_sequence_eigen_count_unit.sv]
// The row rate is set by the pivot unit, which takes one row at a time through the
// radix-16 divider and the three-stage subtractor before it pops the next row.
// The front end accepts a new row only once it has pushed the previous one, so it stalls while the queue is full.
// Reset is synchronous and active high; the pivot returns to 1.0 and the count to zero.
// ----------------------------------------------------------------------------
// Sturm sequence eigenvalue counter
// Counts the eigenvalues of a symmetric tridiagonal matrix below a shift
// using the Sturm pivot recurrence in IEEE single precision.
// ----------------------------------------------------------------------------
module sturm_sequence_eigen_count_unit
   import ssec_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_diag_value,
   input  logic [31:0] req_coupling_value,
   input  logic [31:0] req_shift,
   input  logic        req_last_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_eig_count
);

   logic            push_valid, push_ready;
   queue_entry_type push_data;
   logic            pop_valid, pop_ready;
   queue_entry_type pop_data;

   ssec_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_diag_value     (req_diag_value),
      .req_coupling_value (req_coupling_value),
      .req_shift          (req_shift),
      .req_last_row       (req_last_row),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_data          (push_data)
   );

   ssec_queue #(
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_data),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_data)
   );

   ssec_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_eig_count (rsp_eig_count)
   );

endmodule
